### sv/trt_pkg.sv
`timescale 1ns / 1ps

package trt_pkg;

  localparam int DEFAULT_MAX_THREADS = 8;

  // guard margins in words around live regions
  localparam int ROM_GUARD = 2;
  localparam int RAM_GUARD = 1;

  localparam logic [2:0] ST_NULL   = 3'd0;
  localparam logic [2:0] ST_ACTIVE = 3'd1;
  localparam logic [2:0] ST_IO     = 3'd2;

  typedef enum logic [1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_READ     = 2'd1,
    FUNC_CHECK    = 2'd2,
    FUNC_UNBLOCK  = 2'd3
  } trt_func_t;

  typedef struct packed {
    trt_func_t   func;
    logic [2:0]  index;
    logic [2:0]  thread_state;
    logic [15:0] rom_start;
    logic [15:0] rom_size;
    logic [15:0] ram_base;
    logic [15:0] ram_end;
    logic [7:0]  io_type;
    logic [7:0]  io_id;
  } trt_req_t;

  typedef struct packed {
    logic        conflict;
    logic [7:0]  woken_mask;
    logic [3:0]  woken_count;
    logic [2:0]  entry_state;
  } trt_rsp_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [2:0]  thread_state;
    logic [15:0] rom_start;
    logic [15:0] rom_size;
    logic [15:0] ram_base;
    logic [15:0] ram_end;
    logic [7:0]  io_type;
    logic [7:0]  io_id;
  } trt_rec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } trt_fsm_t;

endpackage

### sv/thread_region_table_unit.sv
`timescale 1ns / 1ps

// Thread region table: one entry per thread (state, flash and RAM region,
// I/O wait tag) held in a single synchronous memory with a registered read
// port. A write request goes straight to S_DONE, a state read passes S_READ
// first, and a conflict check or I/O unblock walks every entry in S_SCAN,
// reading one entry per cycle and, for unblock, writing the woken entry back
// behind the read. One request is worked at a time; the next is taken while
// a finished response still waits in the output register. A per-entry valid
// flop makes unwritten entries read as null, so no clearing pass follows reset.
module thread_region_table_unit
  import trt_pkg::*;
#(
  parameter int MAX_THREADS = DEFAULT_MAX_THREADS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  trt_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output trt_rsp_t rsp
);

  localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_THREADS - 1);
  localparam logic [4:0] DEPTH5 = 5'(MAX_THREADS);

  trt_rec_t mem [MAX_THREADS];
  logic [MAX_THREADS-1:0] live;

  trt_fsm_t state, state_next;

  logic          accept;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_addr_q;
  trt_rec_t      rd_data;
  logic          rd_live;
  logic          rsp_load;

  // request fields held for the walk
  trt_func_t   func;
  logic        index_ok;
  logic [15:0] cand_rom_start;
  logic [16:0] cand_rom_hi;
  logic [15:0] cand_ram_base;
  logic [16:0] cand_ram_hi;
  logic [7:0]  match_type;
  logic [7:0]  match_id;
  trt_rsp_t    res;

  logic        req_index_ok;
  logic [15:0] ent_rom_end;
  logic        ent_takes_part;
  logic        rom_clash;
  logic        ram_clash;
  logic        wake;

  assign accept       = req_valid && !req_stall;
  assign req_index_ok = 5'(req.index) < DEPTH5;

  // per-entry comparisons, all unsigned with the guards moved across
  assign ent_rom_end    = rd_data.rom_start + (rd_data.rom_size >> 1);
  assign ent_takes_part = rd_live && (rd_data.thread_state != ST_NULL) &&
                          (rd_data.rom_start != 16'd0);
  assign rom_clash = !(({1'b0, cand_rom_start} > ({1'b0, ent_rom_end} + 17'(ROM_GUARD))) ||
                       (cand_rom_hi < {1'b0, rd_data.rom_start}));
  assign ram_clash = !(({1'b0, cand_ram_base} > ({1'b0, rd_data.ram_end} + 17'(RAM_GUARD))) ||
                       (cand_ram_hi < {1'b0, rd_data.ram_base}));
  assign wake = rd_live && (rd_data.thread_state == ST_IO) &&
                (rd_data.io_type == match_type) && (rd_data.io_id == match_id);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.func)
            FUNC_WRITE: state_next = S_DONE;
            FUNC_READ:  state_next = S_READ;
            default:    state_next = S_SCAN;
          endcase
        end
      end
      S_READ: state_next = S_DONE;
      S_SCAN: begin
        if (rd_addr_q == LAST_ADDR) state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != S_IDLE);
    rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);
    rd_addr   = rd_addr_q + AW'(1);
    if (state == S_IDLE) begin
      rd_addr = (req.func == FUNC_READ) ? AW'(req.index) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && req.func == FUNC_WRITE && req_index_ok) begin
        live[AW'(req.index)] <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (accept && req.func == FUNC_WRITE && req_index_ok) begin
      mem[AW'(req.index)] <= '{thread_state: req.thread_state,
                               rom_start:    req.rom_start,
                               rom_size:     req.rom_size,
                               ram_base:     req.ram_base,
                               ram_end:      req.ram_end,
                               io_type:      req.io_type,
                               io_id:        req.io_id};
    end else if (state == S_SCAN && func == FUNC_UNBLOCK && wake) begin
      mem[rd_addr_q] <= '{thread_state: ST_ACTIVE,
                          rom_start:    rd_data.rom_start,
                          rom_size:     rd_data.rom_size,
                          ram_base:     rd_data.ram_base,
                          ram_end:      rd_data.ram_end,
                          io_type:      rd_data.io_type,
                          io_id:        rd_data.io_id};
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    rd_live   <= live[rd_addr];
    if (accept) begin
      func           <= req.func;
      index_ok       <= req_index_ok;
      cand_rom_start <= req.rom_start;
      cand_rom_hi    <= {1'b0, req.rom_start} + {2'b0, req.rom_size[15:1]} +
                        17'(ROM_GUARD);
      cand_ram_base  <= req.ram_base;
      cand_ram_hi    <= {1'b0, req.ram_end} + 17'(RAM_GUARD);
      match_type     <= req.io_type;
      match_id       <= req.io_id;
      res            <= '0;
    end
    if (state == S_READ) begin
      res.entry_state <= (index_ok && rd_live) ? rd_data.thread_state : ST_NULL;
    end
    if (state == S_SCAN) begin
      if (func == FUNC_CHECK) begin
        if (ent_takes_part && (rom_clash || ram_clash)) res.conflict <= 1'b1;
      end else if (wake) begin
        // entries above bit 7 fall off the mask; the count saturates
        res.woken_mask <= res.woken_mask | (8'd1 << rd_addr_q);
        if (res.woken_count != 4'hF) res.woken_count <= res.woken_count + 4'd1;
      end
    end
    if (rsp_load) begin
      rsp <= res;
    end
  end

endmodule
